### design/ustc_pkg.sv
`timescale 1ns / 1ps

package ustc_pkg;

  // stages from input register to output register
  localparam int PIPE_DEPTH = 9;

  // seconds per day = 675 * 128, quotient by reciprocal of 675
  localparam logic [25:0] DAY_RECIP    = 26'd50903317;
  localparam logic [24:0] DAY_DIV      = 25'd675;

  // day count to day of 400-year era (era 4 before 2000-03-01, era 5 after)
  localparam logic [15:0] ERA_SPLIT    = 16'd11017;
  localparam logic [17:0] DOE_OFS      = 18'd135080;
  localparam logic [17:0] DOE_LAST     = 18'd146096;
  localparam logic [17:0] CENT_DAYS_1  = 18'd36524;
  localparam logic [17:0] CENT_DAYS_2  = 18'd73048;
  localparam logic [17:0] CENT_DAYS_3  = 18'd109572;
  localparam logic [18:0] Q1460_RECIP  = 19'd367720;
  localparam logic [18:0] YEAR_RECIP   = 19'd367720;
  localparam logic [17:0] DAYS_PER_YR  = 18'd365;
  localparam logic [11:0] ERA4_BASE    = 12'd1600;
  localparam logic [11:0] ERA5_BASE    = 12'd2000;
  localparam logic [11:0] MP_RECIP     = 12'd3427;

  // time of day
  localparam logic [17:0] HOUR_RECIP   = 18'd149131;
  localparam logic [16:0] SECS_PER_HR  = 17'd3600;
  localparam logic [12:0] MIN_RECIP    = 13'd4370;
  localparam logic [11:0] SECS_PER_MIN = 12'd60;

  // weekday, epoch day is a thursday
  localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;
  localparam logic [16:0] WD_RECIP      = 17'd74899;
  localparam logic [15:0] DAYS_PER_WK   = 16'd7;
  localparam logic [2:0]  SUNDAY        = 3'd7;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
  } date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } tod_t;

  // day of march-based year on which each month starts
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

### design/ustc_daysplit.sv
`timescale 1ns / 1ps

module ustc_daysplit import ustc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] unix_seconds,
  output logic [15:0] days,
  output logic [16:0] sod
);

  logic [31:0] secs1;
  logic [50:0] prod1;
  logic [15:0] days_c;
  logic [24:0] rem_c;

  assign days_c = prod1[50:35];
  assign rem_c  = secs1[31:7] - 25'({9'd0, days_c} * DAY_DIV);

  always_ff @(posedge clk) begin
    if (en) begin
      secs1 <= unix_seconds;
      prod1 <= {26'd0, unix_seconds[31:7]} * {25'd0, DAY_RECIP};
      days  <= days_c;
      sod   <= {rem_c[9:0], secs1[6:0]};
    end
  end

endmodule

### design/ustc_date.sv
`timescale 1ns / 1ps

module ustc_date import ustc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] days,
  output date_t       date
);

  logic        era3, era4, era5, era6, era7, era8;
  logic [17:0] doe3, doe4, doe5, doe6;
  logic [36:0] cprod4;
  logic [2:0]  cent4;
  logic        last4;
  logic [17:0] t5;
  logic [36:0] yprod6;
  logic [8:0]  yoe7, yoe8;
  logic [8:0]  doy7, doy8;
  logic [22:0] mprod8;

  logic [8:0]  yoe_c;
  logic [1:0]  yc_c;
  logic [17:0] doy_c;
  logic [10:0] mx_c;
  logic [3:0]  mp_c;
  logic [8:0]  dom_c;

  always_comb begin
    yoe_c = yprod6[35:27];
    if (yoe_c >= 9'd300) begin
      yc_c = 2'd3;
    end else if (yoe_c >= 9'd200) begin
      yc_c = 2'd2;
    end else if (yoe_c >= 9'd100) begin
      yc_c = 2'd1;
    end else begin
      yc_c = 2'd0;
    end
    doy_c = doe6 - ({9'd0, yoe_c} * DAYS_PER_YR + {11'd0, yoe_c[8:2]} - {16'd0, yc_c});
    mx_c  = {doy7, 2'b00} + {2'b00, doy7} + 11'd2;
    mp_c  = mprod8[22:19];
    dom_c = doy8 - month_start(mp_c) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // day of era
      era3 <= (days >= ERA_SPLIT);
      doe3 <= (days >= ERA_SPLIT) ? {2'b00, days} - {2'b00, ERA_SPLIT}
                                  : {2'b00, days} + DOE_OFS;
      // doe / 1460, doe / 36524 and doe / 146096
      era4   <= era3;
      doe4   <= doe3;
      cprod4 <= {19'd0, doe3} * {18'd0, Q1460_RECIP};
      last4  <= (doe3 == DOE_LAST);
      if (doe3 >= DOE_LAST) begin
        cent4 <= 3'd4;
      end else if (doe3 >= CENT_DAYS_3) begin
        cent4 <= 3'd3;
      end else if (doe3 >= CENT_DAYS_2) begin
        cent4 <= 3'd2;
      end else if (doe3 >= CENT_DAYS_1) begin
        cent4 <= 3'd1;
      end else begin
        cent4 <= 3'd0;
      end
      // leap-corrected day count
      era5 <= era4;
      doe5 <= doe4;
      t5   <= doe4 - {11'd0, cprod4[35:29]} + {15'd0, cent4} - {17'd0, last4};
      // year of era
      era6   <= era5;
      doe6   <= doe5;
      yprod6 <= {19'd0, t5} * {18'd0, YEAR_RECIP};
      // day of year
      era7 <= era6;
      yoe7 <= yoe_c;
      doy7 <= doy_c[8:0];
      // month index
      era8   <= era7;
      yoe8   <= yoe7;
      doy8   <= doy7;
      mprod8 <= {12'd0, mx_c} * {11'd0, MP_RECIP};
      // calendar fields
      date.day_of_month <= dom_c[4:0];
      date.month        <= (mp_c >= 4'd10) ? mp_c - 4'd9 : mp_c + 4'd3;
      date.year         <= {3'd0, yoe8} + (era8 ? ERA5_BASE : ERA4_BASE)
                           + {11'd0, (mp_c >= 4'd10)};
    end
  end

endmodule

### design/ustc_tod.sv
`timescale 1ns / 1ps

module ustc_tod import ustc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] days,
  input  logic [16:0] sod,
  output tod_t        tod
);

  logic [16:0] sod3;
  logic [34:0] hprod3;
  logic [15:0] wx3;
  logic [32:0] wprod3;
  logic [4:0]  hour4, hour5;
  logic [11:0] rem4, rem5;
  logic [2:0]  wd4, wd5;
  logic [24:0] mprod5;
  tod_t        tod6, tod7, tod8;

  logic [15:0] wx_c;
  logic [4:0]  hour_c;
  logic [16:0] rem_c;
  logic [12:0] wq_c;
  logic [15:0] wr_c;
  logic [5:0]  min_c;
  logic [11:0] sec_c;

  assign wx_c   = days + EPOCH_WEEKDAY;
  assign hour_c = hprod3[33:29];
  assign rem_c  = sod3 - {12'd0, hour_c} * SECS_PER_HR;
  assign wq_c   = wprod3[31:19];
  assign wr_c   = wx3 - {3'd0, wq_c} * DAYS_PER_WK;
  assign min_c  = mprod5[23:18];
  assign sec_c  = rem5 - {6'd0, min_c} * SECS_PER_MIN;

  always_ff @(posedge clk) begin
    if (en) begin
      sod3   <= sod;
      hprod3 <= {18'd0, sod} * {17'd0, HOUR_RECIP};
      wx3    <= wx_c;
      wprod3 <= {17'd0, wx_c} * {16'd0, WD_RECIP};

      hour4 <= hour_c;
      rem4  <= rem_c[11:0];
      wd4   <= (wr_c[2:0] == 3'd0) ? SUNDAY : wr_c[2:0];

      hour5  <= hour4;
      rem5   <= rem4;
      wd5    <= wd4;
      mprod5 <= {13'd0, rem4} * {12'd0, MIN_RECIP};

      tod6.hour    <= hour5;
      tod6.minute  <= min_c;
      tod6.second  <= sec_c[5:0];
      tod6.weekday <= wd5;

      // line up with the date path
      tod7 <= tod6;
      tod8 <= tod7;
      tod  <= tod8;
    end
  end

endmodule

### design/unix_seconds_to_calendar.sv
`timescale 1ns / 1ps
// channel   direction  handshake            fields
// in        input      in_valid / in_ready  unix_seconds
// out       output     out_valid / out_ready year month day_of_month weekday hour minute second
//
// nine register stages; one item enters per cycle while the output is not stalled
// throughput is set by the shared stall enable: all stages move when the output is free
// a stalled output freezes every stage, so in_ready follows out_ready combinationally
// reset clears only the stage valid bits; the payload path has no reset

module unix_seconds_to_calendar import ustc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] unix_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [2:0]  weekday,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  logic [PIPE_DEPTH-1:0] vld;
  logic                  en;
  logic [15:0]           days;
  logic [16:0]           sod;
  date_t                 date;
  tod_t                  tod;

  assign en        = !vld[PIPE_DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  ustc_daysplit u_daysplit (
    .clk          (clk),
    .en           (en),
    .unix_seconds (unix_seconds),
    .days         (days),
    .sod          (sod)
  );

  ustc_date u_date (
    .clk  (clk),
    .en   (en),
    .days (days),
    .date (date)
  );

  ustc_tod u_tod (
    .clk  (clk),
    .en   (en),
    .days (days),
    .sod  (sod),
    .tod  (tod)
  );

  assign year         = date.year;
  assign month        = date.month;
  assign day_of_month = date.day_of_month;
  assign weekday      = tod.weekday;
  assign hour         = tod.hour;
  assign minute       = tod.minute;
  assign second       = tod.second;

endmodule

### design/ustc_checker.sv
`timescale 1ns / 1ps

module ustc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] unix_seconds,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] year,
  input logic [3:0]  month,
  input logic [4:0]  day_of_month,
  input logic [2:0]  weekday,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second
);

  // no item comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("item shown after reset");

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month)
      && $stable(day_of_month) && $stable(weekday) && $stable(hour)
      && $stable(minute) && $stable(second))
    else $error("stalled item changed");

  // date fields in range
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> year >= 12'd1970 && year <= 12'd2106 && month >= 4'd1
      && month <= 4'd12 && day_of_month >= 5'd1)
    else $error("date out of range");

  // time and weekday fields in range
  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59
      && weekday >= 3'd1 && weekday <= 3'd7)
    else $error("time of day out of range");

endmodule

bind unix_seconds_to_calendar ustc_checker u_ustc_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ustc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int IDLE_PCT = 22;
  localparam int RANDOM_ITEMS = 1150;
  localparam logic [31:0] SECS_DAY = 32'd86400;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  typedef struct {
    logic [31:0] secs;
    bit          drain_first;
  } pending_secs_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] unix_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [2:0]  weekday;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  pending_secs_t pending_secs[$];
  calendar_t     expected_dates[$];
  int            accepted_items = 0;
  int            mismatch_count = 0;
  int            quiet_cycles = 0;
  bit            calm;

  // no idling on either side while this stretch of items goes through
  assign calm = (accepted_items >= 400) && (accepted_items < 650);

  unix_seconds_to_calendar u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .unix_seconds (unix_seconds),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .weekday      (weekday),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // days-to-civil breakdown in march-based 400-year eras
  function automatic calendar_t predict_calendar(input logic [31:0] secs);
    int unsigned days, sod, z, era, doe, yoe, doy, mp, d, m, y, wd;
    calendar_t c;
    days = secs / SECS_DAY;
    sod  = secs % SECS_DAY;
    z    = days + 719468;
    era  = z / 146097;
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    d    = doy - (153 * mp + 2) / 5 + 1;
    m    = (mp < 10) ? mp + 3 : mp - 9;
    y    = yoe + era * 400 + ((m <= 2) ? 1 : 0);
    wd   = (days + 4) % 7;
    if (wd == 0) begin
      wd = 7;
    end
    c.year         = y[11:0];
    c.month        = m[3:0];
    c.day_of_month = d[4:0];
    c.weekday      = wd[2:0];
    c.hour         = 5'(sod / 3600);
    c.minute       = 6'((sod % 3600) / 60);
    c.second       = 6'(sod % 60);
    return c;
  endfunction

  task automatic add_secs(input logic [31:0] secs, input bit drain_first = 1'b0);
    pending_secs_t p;
    p.secs = secs;
    p.drain_first = drain_first;
    pending_secs.push_back(p);
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_dates.push_back(predict_calendar(unix_seconds));
        accepted_items++;
      end
      if (!in_valid || in_ready) begin
        if (pending_secs.size() > 0 &&
            !(pending_secs[0].drain_first && expected_dates.size() > 0) &&
            (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid     <= 1'b1;
          unix_seconds <= pending_secs[0].secs;
          void'(pending_secs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor
  always @(posedge clk) begin
    calendar_t exp_item;
    if (!rst && out_valid && out_ready) begin
      if (expected_dates.size() == 0) begin
        $error("unexpected item: year %0d month %0d day %0d", year, month, day_of_month);
        mismatch_count++;
      end else begin
        exp_item = expected_dates.pop_front();
        check_field("year", exp_item.year, year);
        check_field("month", exp_item.month, month);
        check_field("day_of_month", exp_item.day_of_month, day_of_month);
        check_field("weekday", exp_item.weekday, weekday);
        check_field("hour", exp_item.hour, hour);
        check_field("minute", exp_item.minute, minute);
        check_field("second", exp_item.second, second);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("unix_seconds_to_calendar: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] day_idx;
    int          kind;

    // field extremes and time-of-day edges
    add_secs(32'd0);
    add_secs(32'd1);
    add_secs(32'd59);
    add_secs(32'd60);
    add_secs(32'd3599);
    add_secs(32'd3600);
    add_secs(32'd86399);
    add_secs(32'd86400);
    add_secs(32'd31535999);
    add_secs(32'd31536000);
    // leap day in an ordinary leap year
    add_secs(32'd68169600);
    // around the leap day of 2000 and the start of the next era
    add_secs(32'd951782399);
    add_secs(32'd951782400);
    add_secs(32'd951868799);
    add_secs(32'd951868800);
    // 2100 is not a leap year
    add_secs(32'd4107542399);
    add_secs(32'd4107542400);
    add_secs(32'd4102444799);
    add_secs(32'd2147483647);
    add_secs(32'd2147483648);
    add_secs(32'haaaaaaaa);
    add_secs(32'h55555555);
    add_secs(32'hfffffffe);
    add_secs(32'hffffffff);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(9);
      day_idx = $urandom_range(49709);
      if (kind < 6) begin
        add_secs($urandom(), (i == 0) || (i == 800));
      end else if (kind < 8) begin
        // just before or at midnight
        add_secs(day_idx * SECS_DAY + ($urandom_range(1) ? 32'd0 : 32'd86399)
                 - ((day_idx == 0) ? 32'd0 : 32'd0));
      end else if (day_idx < 49710) begin
        // anywhere within the last 200 days below the top of the range
        add_secs(32'hffffffff - $urandom_range(200 * 86400));
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_secs.size() > 0 || in_valid || expected_dates.size() > 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DEPTH * 4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("unix_seconds_to_calendar: match");
    end else begin
      $display("unix_seconds_to_calendar: mismatch");
    end
    $finish;
  end

endmodule
